/* design/header_payload_document_parser_macros.svh */
// Assertion macros for the header/payload document parser.
// Included by the top level; the NO_ASSERTIONS macro removes every check.
`ifndef HEADER_PAYLOAD_DOCUMENT_PARSER_MACROS_SVH
`define HEADER_PAYLOAD_DOCUMENT_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HPDP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hpdp implication check failed");
`define HPDP_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("hpdp forbidden condition seen");
`else
`define HPDP_ASSERT_IMP(label, ante, cons)
`define HPDP_ASSERT_NEVER(label, cond)
`endif
`endif

/* design/hpdp_pkg.sv */
// Shared types and constants of the header/payload document parser.
// Used by the front, queue and back modules and the top level.
`default_nettype none
package hpdp_pkg;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LINE  = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h00;

	localparam logic [7:0] CAP_RESET = 8'd16;

	localparam int ADDR_W = 2;
	localparam logic [ADDR_W-1:0] CFG_ADDR_CAP = '0;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		PH_LEAD    = 3'd0,
		PH_NAME    = 3'd1,
		PH_STAR    = 3'd2,
		PH_COLON2  = 3'd3,
		PH_VALUE   = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		CL_DELIM   = 3'd0,
		CL_NAME    = 3'd1,
		CL_VALUE   = 3'd2,
		CL_PAYLOAD = 3'd3,
		CL_IGNORED = 3'd4
	} byte_class_t;

	typedef enum logic [2:0] {
		ST_RUN     = 3'd0,
		ST_FIELD   = 3'd1,
		ST_PAYLOAD = 3'd2,
		ST_END     = 3'd3,
		ST_BADDEL  = 3'd4,
		ST_TOOMANY = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		K_OTHER = 3'd0,
		K_ZERO  = 3'd1,
		K_COLON = 3'd2,
		K_COMMA = 3'd3,
		K_STAR  = 3'd4,
		K_LINE  = 3'd5
	} char_kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		char_kind_t kind;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage
`default_nettype wire

/* design/hpdp_if.sv */
// Valid/ready channel interfaces for document bytes and classified results.
// Stand-alone; widths follow the byte and code formats of the parser.
`default_nettype none
interface hpdp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source(output valid, output data_byte, output first_byte, input ready);
	modport sink(input valid, input data_byte, input first_byte, output ready);
endinterface

interface hpdp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic [2:0] byte_class;
	logic [7:0] field_index;
	logic [2:0] status;

	modport source(output valid, output byte_out, output byte_class, output field_index,
		output status, input ready);
	modport sink(input valid, input byte_out, input byte_class, input field_index,
		input status, output ready);
endinterface
`default_nettype wire

/* design/header_payload_document_parser.sv */
// Top level of the header/payload document parser: configuration port and assembly.
// Depends on hpdp_pkg, hpdp_if, hpdp_front, hpdp_queue, hpdp_back and the macros header.
//
// Channel   Direction  Transaction
// in_ch     sink       one document byte with its first_byte flag
// out_ch    source     echoed byte, class, field index and status
// APB       slave      field_capacity at byte address 0
//
// One transaction is accepted per cycle and one result delivered per cycle when
// out_ch is ready; a result is registered first by the two-entry queue write and
// then by the back end result register.
// Reset clears the parse state and the queue and sets field_capacity to 16.
// A stall on out_ch fills the queue, after which in_ch.ready drops.
`default_nettype none
`include "header_payload_document_parser_macros.svh"
module header_payload_document_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	hpdp_in_if.sink                       in_ch,
	hpdp_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hpdp_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [7:0]            cap_q;
	logic                  push;
	logic                  pop;
	hpdp_pkg::entry_t      push_entry;
	hpdp_pkg::entry_t      pop_entry;
	hpdp_pkg::queue_stat_t q_stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= hpdp_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && paddr == hpdp_pkg::CFG_ADDR_CAP) begin
			cap_q <= pwdata[7:0];
		end
	end

	assign prdata = (paddr == hpdp_pkg::CFG_ADDR_CAP) ? {24'd0, cap_q} : 32'd0;

	hpdp_front u_front (
		.in_ch      (in_ch),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	hpdp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.stat       (q_stat)
	);

	hpdp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.field_capacity (cap_q),
		.entry          (pop_entry),
		.q_stat         (q_stat),
		.pop            (pop),
		.out_ch         (out_ch)
	);

	`HPDP_ASSERT_NEVER(a_pop_when_empty, pop && q_stat.empty)
	`HPDP_ASSERT_IMP(a_error_is_ignored,
		out_ch.valid && (out_ch.status == hpdp_pkg::ST_END ||
		out_ch.status == hpdp_pkg::ST_BADDEL || out_ch.status == hpdp_pkg::ST_TOOMANY),
		out_ch.byte_class == hpdp_pkg::CL_IGNORED)
	`HPDP_ASSERT_IMP(a_marker_is_delim,
		out_ch.valid && (out_ch.status == hpdp_pkg::ST_FIELD ||
		out_ch.status == hpdp_pkg::ST_PAYLOAD),
		out_ch.byte_class == hpdp_pkg::CL_DELIM)

endmodule
`default_nettype wire

/* design/hpdp_front.sv */
// Front end: accepts document bytes and decodes each into a character kind.
// Depends on hpdp_pkg and hpdp_in_if; feeds hpdp_queue.
`default_nettype none
module hpdp_front (
	hpdp_in_if.sink              in_ch,
	input  hpdp_pkg::queue_stat_t q_stat,
	output logic                 push,
	output hpdp_pkg::entry_t     push_entry
);

	hpdp_pkg::char_kind_t kind;

	always_comb begin
		unique case (in_ch.data_byte)
			hpdp_pkg::CH_ZERO:  kind = hpdp_pkg::K_ZERO;
			hpdp_pkg::CH_COLON: kind = hpdp_pkg::K_COLON;
			hpdp_pkg::CH_COMMA: kind = hpdp_pkg::K_COMMA;
			hpdp_pkg::CH_STAR:  kind = hpdp_pkg::K_STAR;
			hpdp_pkg::CH_LINE:  kind = hpdp_pkg::K_LINE;
			default:            kind = hpdp_pkg::K_OTHER;
		endcase
	end

	assign in_ch.ready      = !q_stat.full;
	assign push             = in_ch.valid && !q_stat.full;
	assign push_entry.data  = in_ch.data_byte;
	assign push_entry.first = in_ch.first_byte;
	assign push_entry.kind  = kind;

endmodule
`default_nettype wire

/* design/hpdp_queue.sv */
// Short queue of decoded bytes between the front end and the parsing back end.
// Depends on hpdp_pkg for the entry type and depth.
`default_nettype none
module hpdp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  hpdp_pkg::entry_t      push_entry,
	input  logic                  pop,
	output hpdp_pkg::entry_t      pop_entry,
	output hpdp_pkg::queue_stat_t stat
);

	hpdp_pkg::entry_t                  mem_q [hpdp_pkg::QDEPTH];
	logic [hpdp_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [hpdp_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [hpdp_pkg::QCNT_W-1:0]       cnt_q;

	localparam logic [hpdp_pkg::QPTR_W-1:0] PTR_LAST = hpdp_pkg::QPTR_W'(hpdp_pkg::QDEPTH - 1);
	localparam logic [hpdp_pkg::QCNT_W-1:0] CNT_FULL = hpdp_pkg::QCNT_W'(hpdp_pkg::QDEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign pop_entry  = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CNT_FULL);
	assign stat.empty = (cnt_q == '0);

endmodule
`default_nettype wire

/* design/hpdp_back.sv */
// Back end: runs the document state machine on queued bytes and registers results.
// Depends on hpdp_pkg, hpdp_out_if and the entries delivered by hpdp_queue.
`default_nettype none
module hpdp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            field_capacity,
	input  hpdp_pkg::entry_t      entry,
	input  hpdp_pkg::queue_stat_t q_stat,
	output logic                  pop,
	hpdp_out_if.source            out_ch
);

	hpdp_pkg::phase_t      phase_q;
	logic [7:0]            fields_q;
	logic                  fin_q;

	hpdp_pkg::phase_t      phase_e;
	logic [7:0]            fields_e;
	logic                  fin_e;

	hpdp_pkg::phase_t      phase_n;
	logic [7:0]            fields_n;
	logic                  fin_n;

	hpdp_pkg::byte_class_t cls;
	hpdp_pkg::status_t     st;
	logic                  err;

	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	hpdp_pkg::byte_class_t out_class_q;
	logic [7:0]            out_index_q;
	hpdp_pkg::status_t     out_status_q;

	assign pop = !q_stat.empty && (!out_valid_q || out_ch.ready);

	always_comb begin
		phase_e  = entry.first ? hpdp_pkg::PH_LEAD : phase_q;
		fields_e = entry.first ? 8'd0 : fields_q;
		fin_e    = entry.first ? 1'b0 : fin_q;
	end

	always_comb begin
		cls = hpdp_pkg::CL_IGNORED;
		st  = hpdp_pkg::ST_RUN;
		if (!fin_e) begin
			unique case (phase_e)
				hpdp_pkg::PH_NAME: begin
					priority if (entry.kind == hpdp_pkg::K_ZERO) st = hpdp_pkg::ST_END;
					else if (entry.kind == hpdp_pkg::K_COLON) cls = hpdp_pkg::CL_DELIM;
					else if (entry.kind == hpdp_pkg::K_COMMA) cls = hpdp_pkg::CL_DELIM;
					else cls = hpdp_pkg::CL_NAME;
				end
				hpdp_pkg::PH_STAR: begin
					priority if (entry.kind == hpdp_pkg::K_ZERO) st = hpdp_pkg::ST_END;
					else if (entry.kind == hpdp_pkg::K_STAR) cls = hpdp_pkg::CL_DELIM;
					else st = hpdp_pkg::ST_BADDEL;
				end
				hpdp_pkg::PH_COLON2: begin
					priority if (entry.kind == hpdp_pkg::K_ZERO) st = hpdp_pkg::ST_END;
					else if (entry.kind == hpdp_pkg::K_COLON) begin
						cls = hpdp_pkg::CL_DELIM;
						st  = hpdp_pkg::ST_PAYLOAD;
					end else st = hpdp_pkg::ST_BADDEL;
				end
				hpdp_pkg::PH_VALUE: begin
					if (entry.kind == hpdp_pkg::K_ZERO || entry.kind == hpdp_pkg::K_LINE) begin
						priority if (fields_e >= field_capacity) st = hpdp_pkg::ST_TOOMANY;
						else if (entry.kind == hpdp_pkg::K_ZERO) st = hpdp_pkg::ST_END;
						else begin
							cls = hpdp_pkg::CL_DELIM;
							st  = hpdp_pkg::ST_FIELD;
						end
					end else begin
						cls = hpdp_pkg::CL_VALUE;
					end
				end
				hpdp_pkg::PH_PAYLOAD: begin
					if (entry.kind != hpdp_pkg::K_ZERO) cls = hpdp_pkg::CL_PAYLOAD;
				end
				default: begin
					priority if (entry.kind == hpdp_pkg::K_ZERO) st = hpdp_pkg::ST_END;
					else if (entry.kind == hpdp_pkg::K_COLON) cls = hpdp_pkg::CL_DELIM;
					else st = hpdp_pkg::ST_BADDEL;
				end
			endcase
			if (st == hpdp_pkg::ST_END || st == hpdp_pkg::ST_BADDEL ||
				st == hpdp_pkg::ST_TOOMANY) cls = hpdp_pkg::CL_IGNORED;
		end
	end

	assign err = (st == hpdp_pkg::ST_END) || (st == hpdp_pkg::ST_BADDEL) ||
		(st == hpdp_pkg::ST_TOOMANY);

	always_comb begin
		phase_n  = phase_e;
		fields_n = fields_e;
		fin_n    = fin_e;
		if (!fin_e) begin
			if (err) begin
				fin_n = 1'b1;
			end else begin
				unique case (phase_e)
					hpdp_pkg::PH_NAME: begin
						if (entry.kind == hpdp_pkg::K_COLON) phase_n = hpdp_pkg::PH_VALUE;
						if (entry.kind == hpdp_pkg::K_COMMA) phase_n = hpdp_pkg::PH_STAR;
					end
					hpdp_pkg::PH_STAR:   phase_n = hpdp_pkg::PH_COLON2;
					hpdp_pkg::PH_COLON2: phase_n = hpdp_pkg::PH_PAYLOAD;
					hpdp_pkg::PH_VALUE: begin
						if (st == hpdp_pkg::ST_FIELD) begin
							fields_n = fields_e + 8'd1;
							phase_n  = hpdp_pkg::PH_LEAD;
						end
					end
					hpdp_pkg::PH_PAYLOAD: begin
						if (entry.kind == hpdp_pkg::K_ZERO) fin_n = 1'b1;
					end
					default: phase_n = hpdp_pkg::PH_NAME;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hpdp_pkg::PH_LEAD;
			fields_q    <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q  <= phase_n;
				fields_q <= fields_n;
				fin_q    <= fin_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q   <= entry.data;
			out_class_q  <= cls;
			out_index_q  <= fields_e;
			out_status_q <= st;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.byte_out    = out_byte_q;
	assign out_ch.byte_class  = out_class_q;
	assign out_ch.field_index = out_index_q;
	assign out_ch.status      = out_status_q;

endmodule
`default_nettype wire
